>>> hw/rtl/mixing_ring_buffer_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef MIXING_RING_BUFFER_CORE_MACROS_SVH
`define MIXING_RING_BUFFER_CORE_MACROS_SVH

// Check on every edge outside reset.
`define MRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define MRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mrb_pkg.sv
package mrb_pkg;

  typedef enum logic [1:0] {
    OP_QUERY    = 2'd0,
    OP_WRITE    = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // copy_mode value that marks a fresh frame
  localparam logic [1:0] CM_FRESH = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = 2;
  localparam int OCW         = 3;

  // offset is already reduced modulo the ring depth once it sits in the queue
  typedef struct packed {
    op_t                operation;
    logic [11:0]        offset;
    logic signed [15:0] sample;
    logic               burst;
    logic               idle;
  } queue_item_t;

  function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7fff;
    end
    return s[15:0];
  endfunction

endpackage

>>> hw/rtl/mrb_front.sv
module mrb_front
  import mrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [11:0]        offset,
  input  logic signed [15:0] sample_in,
  input  logic               burst_start,
  input  logic               streams_idle,
  input  logic               clearing,
  input  logic               pop,
  output logic               busy,
  output logic               push,
  output queue_item_t        push_item
);

  localparam int PW  = $clog2(BUFFER_DEPTH);
  localparam int SH  = 12 + PW;
  localparam int MW  = 14;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(BUFFER_DEPTH) - 1)
                             / longint'(BUFFER_DEPTH);
  localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
  localparam logic [11:0]   DEPTH12 = 12'(BUFFER_DEPTH);

  logic               accept;
  logic [OCW-1:0]     occ;
  logic [OCW-1:0]     occ_next;
  logic               v1;
  logic               v2;
  queue_item_t        s1;
  queue_item_t        s2;
  logic [SH+11:0]     prod1;
  logic [11:0]        q1;
  logic [23:0]        qd_full;
  logic [11:0]        qd2;

  // credit count: items between the accept and the back end's pop
  assign busy     = clearing || (occ == OCW'(QUEUE_DEPTH));
  assign accept   = start && !busy;
  assign occ_next = occ + OCW'(accept) - OCW'(pop);

  assign q1      = prod1[SH +: 12];
  assign qd_full = q1 * DEPTH12;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      occ <= occ_next;
      v1  <= accept;
      v2  <= v1;
    end
    s1.operation <= op_t'(operation);
    s1.offset    <= offset;
    s1.sample    <= sample_in;
    s1.burst     <= burst_start;
    s1.idle      <= streams_idle;
    // quotient by reciprocal, exact for any 12-bit offset
    prod1        <= (SH+12)'(offset) * (SH+12)'(RECIP_W);
    s2           <= s1;
    qd2          <= qd_full[11:0];
  end

  always_comb begin
    push             = v2;
    push_item        = s2;
    push_item.offset = s2.offset - qd2;
  end

endmodule

>>> hw/rtl/mrb_queue.sv
module mrb_queue
  import mrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  input  logic        pop,
  output logic        valid,
  output queue_item_t head
);

  queue_item_t      entries [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/mrb_back.sv
module mrb_back
  import mrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  queue_item_t        q_item,
  output logic               pop,
  output logic               clearing,
  output logic               done,
  output logic signed [15:0] sample_out,
  output logic [11:0]        space
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int SW = (PW > 12 ? PW : 12) + 1;
  localparam logic [PW-1:0] LAST    = PW'(BUFFER_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W = (PW+1)'(BUFFER_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);

  back_state_t        state;
  back_state_t        state_next;
  logic [PW-1:0]      rp, rp_next;
  logic [PW-1:0]      wp, wp_next;
  logic [PW-1:0]      lp, lp_next;
  logic [1:0]         cm, cm_next;
  queue_item_t        cur, cur_next;
  logic [PW-1:0]      addr, addr_next;
  logic [PW-1:0]      clr, clr_next;
  logic               done_next;
  logic signed [15:0] sample_out_next;
  logic [11:0]        space_next;

  logic signed [15:0] mem [BUFFER_DEPTH];
  logic signed [15:0] rdata;
  logic               mem_we;
  logic [PW-1:0]      mem_wa;
  logic signed [15:0] mem_wd;
  logic [PW-1:0]      mem_ra;

  logic [PW-1:0]      lp_eff;
  logic [PW:0]        n;
  logic [PW+12:0]     n_ext;
  logic [SW-1:0]      sum;
  logic [SW-1:0]      sum_red;
  logic [PW-1:0]      pos;
  logic [1:0]         cm_eff;
  logic signed [15:0] mix;

  assign clearing = (state == BK_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr == LAST) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && (q_item.operation == OP_WRITE || q_item.operation == OP_READ)) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: state_next = BK_IDLE;
      default: state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    // a new frame latches the limit at the read pointer
    lp_eff = (cm == CM_FRESH) ? rp : lp;
    if (wp > lp_eff) begin
      n = DEPTH_W - (PW+1)'(wp) + (PW+1)'(lp_eff);
    end else begin
      n = (PW+1)'(lp_eff) - (PW+1)'(wp);
    end
    n_ext   = {12'd0, n};
    sum     = SW'(wp) + SW'(q_item.offset);
    sum_red = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
    pos     = sum_red[PW-1:0];
    cm_eff  = cur.burst ? (cm >> 1) : cm;
    mix     = sat_add16(rdata, cur.sample);

    pop             = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = addr;
    mem_wd          = '0;
    mem_ra          = addr;
    rp_next         = rp;
    wp_next         = wp;
    lp_next         = lp;
    cm_next         = cm;
    cur_next        = cur;
    addr_next       = addr;
    clr_next        = clr;
    done_next       = 1'b0;
    sample_out_next = '0;
    space_next      = '0;

    case (state)
      BK_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr;
        clr_next = clr + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          cur_next = q_item;
          case (q_item.operation)
            OP_QUERY: begin
              lp_next    = lp_eff;
              done_next  = 1'b1;
              space_next = n_ext[11:0];
            end
            OP_WRITE: begin
              addr_next = pos;
              mem_ra    = pos;
            end
            OP_COMPLETE: begin
              cm_next   = CM_FRESH;
              wp_next   = lp;
              done_next = 1'b1;
            end
            OP_READ: begin
              addr_next = rp;
              mem_ra    = rp;
            end
            default: ;
          endcase
        end
      end
      BK_EXEC: begin
        done_next = 1'b1;
        case (cur.operation)
          OP_WRITE: begin
            cm_next = cm_eff;
            mem_we  = 1'b1;
            mem_wd  = (cm_eff != 2'd0) ? cur.sample : mix;
          end
          OP_READ: begin
            sample_out_next = rdata;
            // drop the slot once consumed when nothing is streaming
            mem_we  = cur.idle;
            rp_next = (rp == LAST) ? '0 : rp + 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clr        <= '0;
      rp         <= '0;
      wp         <= '0;
      lp         <= '0;
      cm         <= CM_FRESH;
      done       <= 1'b0;
      sample_out <= '0;
      space      <= '0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      rp         <= rp_next;
      wp         <= wp_next;
      lp         <= lp_next;
      cm         <= cm_next;
      done       <= done_next;
      sample_out <= sample_out_next;
      space      <= space_next;
    end
    cur  <= cur_next;
    addr <= addr_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

endmodule

>>> hw/rtl/mixing_ring_buffer_core.sv
// Mixing ring buffer of signed 16-bit samples. Issue one command per start
// pulse while busy is low; each command gives exactly one result, shown on
// sample_out and space for the single cycle in which done is high, and the
// receiver cannot stall it. A command passes the front end's registers and
// the queue to the back end, which answers a space query or frame completion
// from its idle state and a sample write or read from its execute state,
// after any wait behind earlier commands. Up to four accepted commands may
// wait ahead of the back end; its execute loop for a write or read (one
// read-modify-write of the sample memory) sets the sustained rate. After
// reset busy stays high while the sample memory is cleared.
module mixing_ring_buffer_core
  import mrb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [11:0]        offset,
  input  logic signed [15:0] sample_in,
  input  logic               burst_start,
  input  logic               streams_idle,
  output logic               done,
  output logic signed [15:0] sample_out,
  output logic [11:0]        space
);

  logic        clearing;
  logic        pop;
  logic        push;
  queue_item_t push_item;
  logic        q_valid;
  queue_item_t q_item;

  mrb_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .offset      (offset),
    .sample_in   (sample_in),
    .burst_start (burst_start),
    .streams_idle(streams_idle),
    .clearing    (clearing),
    .pop         (pop),
    .busy        (busy),
    .push        (push),
    .push_item   (push_item)
  );

  mrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_item)
  );

  mrb_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .sample_out(sample_out),
    .space     (space)
  );

endmodule

>>> hw/rtl/mrb_checker.sv
`include "mixing_ring_buffer_core_macros.svh"

module mrb_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] sample_out,
  input logic [11:0]        space
);

  `MRB_ASSERT_ALWAYS(a_busy_after_reset, rst |=> busy, "busy low right after reset")
  `MRB_ASSERT_ALWAYS(a_no_done_after_reset, rst |=> !done, "done right after reset")
  `MRB_ASSERT(a_quiet_outputs, !done |-> (sample_out == 16'sd0 && space == 12'd0), "result ports not zero without done")
  `MRB_ASSERT(a_single_field, done |-> (sample_out == 16'sd0 || space == 12'd0), "sample and space both set")

endmodule

bind mixing_ring_buffer_core mrb_checker u_mrb_checker (.*);
